[src/tss_pkg.sv]
// ----------------------------------------------------------------------------
// Topological sort package
// Shared transaction types, cell record and cell control for the sorter.
// ----------------------------------------------------------------------------
package tss_pkg;

    typedef struct packed {
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic        last_row;
    } t_in_item;

    typedef struct packed {
        logic [3:0] vertex;
        logic       cycle_found;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_COUNT = 2'd2,
        OP_SCAN  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [15:0] row;
        logic [4:0]  deg;
        logic        enq;
        logic [3:0]  id;
    } t_rec;

    typedef struct packed {
        t_cell_op    op;
        logic [4:0]  n;
        logic [15:0] row0;
        logic [15:0] src_row;
        logic        load_en;
        logic [3:0]  load_idx;
        logic [15:0] load_row;
        logic        clear;
    } t_cell_ctl;

endpackage

[src/tss_cell.sv]
// ----------------------------------------------------------------------------
// Sorter ring cell
// Holds one vertex record and passes it to its neighbor while the ring turns.
// ----------------------------------------------------------------------------
module tss_cell #(
    parameter int CELL_IDX = 0,
    parameter bit IS_HEAD  = 1'b0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tss_pkg::t_cell_ctl i_ctl,
    input  tss_pkg::t_rec      i_nbr,
    output tss_pkg::t_rec      o_rec,
    output tss_pkg::t_rec      o_upd,
    output logic               o_push
);

    tss_pkg::t_rec r_rec;
    logic          w_valid;
    logic          w_dec;
    logic [4:0]    w_newdeg;

    assign w_valid  = {1'b0, r_rec.id} < i_ctl.n;
    assign w_dec    = i_ctl.src_row[r_rec.id] && (r_rec.deg != 5'd0);
    assign w_newdeg = w_dec ? (r_rec.deg - 5'd1) : r_rec.deg;

    always_comb begin
        o_upd  = r_rec;
        o_push = 1'b0;
        case (i_ctl.op)
            tss_pkg::OP_COUNT: begin
                o_upd.deg = r_rec.deg + {4'd0, (w_valid && i_ctl.row0[r_rec.id])};
            end
            tss_pkg::OP_SCAN: begin
                if (IS_HEAD && w_valid) begin
                    o_push    = (w_newdeg == 5'd0) && !r_rec.enq;
                    o_upd.deg = w_newdeg;
                    o_upd.enq = r_rec.enq || o_push;
                end
            end
            default: begin
                o_upd = r_rec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.deg <= 5'd0;
            r_rec.enq <= 1'b0;
            r_rec.id  <= 4'(CELL_IDX);
        end else begin
            case (i_ctl.op)
                tss_pkg::OP_LOAD: begin
                    if (i_ctl.load_en && (i_ctl.load_idx == 4'(CELL_IDX))) begin
                        r_rec.row <= i_ctl.load_row;
                    end
                    if (i_ctl.clear) begin
                        r_rec.deg <= 5'd0;
                        r_rec.enq <= 1'b0;
                    end
                end
                tss_pkg::OP_COUNT, tss_pkg::OP_SCAN: begin
                    r_rec <= i_nbr;
                end
                default: begin
                    r_rec <= r_rec;
                end
            endcase
        end
    end

    assign o_rec = r_rec;

endmodule

[src/topological_sort_source_removal.sv]
// ----------------------------------------------------------------------------
// Topological sort by source removal
// Loads adjacency rows of a directed graph and emits a topological order.
// ----------------------------------------------------------------------------
// Each row transaction is taken when start is high and busy is low. The row
// marked last_row starts the sort and busy stays high until the cycle that
// presents the final result. The vertex count is written through i_cfg_we
// and i_cfg_wdata; the user must write it only while the block is idle, and
// the block itself does not enforce this.
// The vertex records sit in a ring of cells that turns one step per cycle
// while counting or scanning. Counting in-degrees takes one full turn of the
// ring, seeding the source queue another turn, and each popped source costs
// a pop state plus one more turn. The n results then follow, one per cycle.
// Each result is valid on o_result for one cycle, marked by o_valid; the
// receiver cannot stall. A graph with a cycle yields one flagged result.
// Reset sets the vertex count to its maximum and returns the block to idle;
// adjacency rows must be written before they are used by a sort.
// ----------------------------------------------------------------------------
module topological_sort_source_removal #(
    parameter int MAX_VERTICES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tss_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    output logic               o_valid,
    output tss_pkg::t_out_item o_result
);

    localparam int VLIMIT = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
    localparam int IW     = $clog2(VLIMIT);
    localparam int CW     = $clog2(VLIMIT + 1);
    localparam logic [4:0]    VLIMIT_W = 5'(VLIMIT);
    localparam logic [IW-1:0] ROT_LAST = IW'(VLIMIT - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COUNT = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_POP   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_rot, n_rot;
    logic [CW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_tail, n_tail;
    logic [4:0]         r_n, n_n;
    logic [15:0]        r_src_row, n_src_row;
    logic [4:0]         r_vertex_count;
    logic [3:0]         r_fifo [VLIMIT];
    logic               r_out_valid, n_out_valid;
    tss_pkg::t_out_item r_out, n_out;

    tss_pkg::t_cell_ctl w_ctl;
    tss_pkg::t_rec      w_rec [VLIMIT];
    tss_pkg::t_rec      w_upd [VLIMIT];
    logic [VLIMIT-1:0]  w_push;
    logic               w_push_any;
    logic               w_accept;
    logic [4:0]         w_n_cfg;
    logic [3:0]         w_rd_vertex;
    logic [IW-1:0]      w_src_idx;

    genvar gc;
    generate
        for (gc = 0; gc < VLIMIT; gc++) begin : g_cell
            tss_cell #(
                .CELL_IDX (gc),
                .IS_HEAD  (gc == 0)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_nbr   (w_upd[(gc + 1) % VLIMIT]),
                .o_rec   (w_rec[gc]),
                .o_upd   (w_upd[gc]),
                .o_push  (w_push[gc])
            );
        end
    endgenerate

    assign w_accept    = start && (r_state == ST_IDLE);
    assign w_push_any  = |w_push;
    assign w_rd_vertex = r_fifo[r_head[IW-1:0]];
    assign w_src_idx   = w_rd_vertex[IW-1:0];

    always_comb begin
        if (r_vertex_count == 5'd0) begin
            w_n_cfg = 5'd1;
        end else if (r_vertex_count > VLIMIT_W) begin
            w_n_cfg = VLIMIT_W;
        end else begin
            w_n_cfg = r_vertex_count;
        end
    end

    always_comb begin
        w_ctl.n        = r_n;
        w_ctl.row0     = (5'(r_rot) < r_n) ? w_rec[0].row : 16'd0;
        w_ctl.src_row  = r_src_row;
        w_ctl.load_en  = {1'b0, i_item.row_index} < VLIMIT_W;
        w_ctl.load_idx = i_item.row_index;
        w_ctl.load_row = i_item.row_bits;
        w_ctl.clear    = i_item.last_row;
        case (r_state)
            ST_IDLE:  w_ctl.op = w_accept ? tss_pkg::OP_LOAD : tss_pkg::OP_HOLD;
            ST_COUNT: w_ctl.op = tss_pkg::OP_COUNT;
            ST_SCAN:  w_ctl.op = tss_pkg::OP_SCAN;
            default:  w_ctl.op = tss_pkg::OP_HOLD;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_rot       = r_rot;
        n_head      = r_head;
        n_tail      = r_tail;
        n_n         = r_n;
        n_src_row   = r_src_row;
        n_out_valid = 1'b0;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_item.last_row) begin
                    n_n     = w_n_cfg;
                    n_head  = '0;
                    n_tail  = '0;
                    n_rot   = '0;
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_rot = r_rot + 1'b1;
                if (r_rot == ROT_LAST) begin
                    n_rot     = '0;
                    n_src_row = 16'd0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_tail = r_tail + CW'(w_push_any);
                n_rot  = r_rot + 1'b1;
                if (r_rot == ROT_LAST) begin
                    n_rot = '0;
                    if (n_tail != r_head) begin
                        n_state = ST_POP;
                    end else if (5'(n_tail) == r_n) begin
                        n_head  = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_out.vertex      = 4'd0;
                        n_out.cycle_found = 1'b1;
                        n_out.last        = 1'b1;
                        n_out_valid       = 1'b1;
                        n_state           = ST_IDLE;
                    end
                end
            end
            ST_POP: begin
                n_src_row = w_rec[w_src_idx].row;
                n_head    = r_head + 1'b1;
                n_state   = ST_SCAN;
            end
            ST_EMIT: begin
                n_out.vertex      = w_rd_vertex;
                n_out.cycle_found = 1'b0;
                n_out.last        = (5'(r_head) + 5'd1) == r_n;
                n_out_valid       = 1'b1;
                n_head            = r_head + 1'b1;
                if (n_out.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_rot          <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_n            <= VLIMIT_W;
            r_vertex_count <= 5'd16;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rot       <= n_rot;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_row <= n_src_row;
        r_out     <= n_out;
        if ((r_state == ST_SCAN) && w_push_any) begin
            r_fifo[r_tail[IW-1:0]] <= w_rec[0].id;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[tb/tss_order_checker.sv]
// ----------------------------------------------------------------------------
// Topological order checker
// Watches the row, configuration and result channels of the sorter. It keeps
// its own copy of the adjacency rows and the vertex count, works out the
// expected order for every sort and compares each result field by field.
// ----------------------------------------------------------------------------
module tss_order_checker #(
    parameter int MAX_VERTICES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  tss_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               i_valid,
    input  tss_pkg::t_out_item i_result,
    input  logic               i_done,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VERT_LIMIT = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

    logic [15:0]        adj_rows [16];
    logic [4:0]         vert_count = 5'd16;
    tss_pkg::t_out_item expected_order [$];
    int                 fails = 0;
    int                 pending = 0;
    bit                 done_seen = 1'b0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    task automatic report(string what, int got, int want);
        $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    task automatic predict_topo_order();
        int unsigned        n, emitted, i, j;
        logic [4:0]         deg [16];
        logic [15:0]        queued;
        logic [3:0]         sources [$];
        logic [3:0]         order [16];
        logic [3:0]         src;
        tss_pkg::t_out_item res;
        n = (vert_count == 0) ? 1 : ((vert_count > VERT_LIMIT) ? VERT_LIMIT : vert_count);
        emitted = 0;
        queued = '0;
        for (i = 0; i < 16; i++) begin
            deg[i] = '0;
        end
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                if (adj_rows[j][i] === 1'b1) begin
                    deg[i]++;
                end
            end
            if (deg[i] == 0 && sources.size() < n) begin
                sources.push_back(4'(i));
                queued[i] = 1'b1;
            end
        end
        while (sources.size() != 0) begin
            src = sources.pop_front();
            if (emitted < n) begin
                order[emitted] = src;
                emitted++;
            end
            for (j = 0; j < n; j++) begin
                if (adj_rows[src][j] === 1'b1 && deg[j] != 0) begin
                    deg[j]--;
                end
                if (deg[j] == 0 && !queued[j] && sources.size() < n) begin
                    sources.push_back(4'(j));
                    queued[j] = 1'b1;
                end
            end
        end
        if (emitted != n) begin
            res.vertex      = '0;
            res.cycle_found = 1'b1;
            res.last        = 1'b1;
            expected_order.push_back(res);
        end else begin
            for (i = 0; i < n; i++) begin
                res.vertex      = order[i];
                res.cycle_found = 1'b0;
                res.last        = (i + 1 == n);
                expected_order.push_back(res);
            end
        end
    endtask

    task automatic check_result(tss_pkg::t_out_item got);
        tss_pkg::t_out_item want;
        if (expected_order.size() == 0) begin
            report("result with nothing expected, vertex", got.vertex, 0);
            return;
        end
        want = expected_order.pop_front();
        if (got.vertex !== want.vertex) begin
            report("vertex", got.vertex, want.vertex);
        end
        if (got.cycle_found !== want.cycle_found) begin
            report("cycle_found", got.cycle_found, want.cycle_found);
        end
        if (got.last !== want.last) begin
            report("last", got.last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vert_count = 5'd16;
            expected_order.delete();
        end else begin
            if (i_valid === 1'b1) begin
                check_result(i_result);
            end
            if (i_cfg_we) begin
                vert_count = i_cfg_wdata;
            end
            if (i_start && i_busy === 1'b0) begin
                if (int'(i_item.row_index) < VERT_LIMIT) begin
                    adj_rows[i_item.row_index] = i_item.row_bits;
                end
                if (i_item.last_row) begin
                    predict_topo_order();
                end
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (expected_order.size() != 0) begin
                    report("expected results never sent", 0, expected_order.size());
                end
            end
        end
        pending = expected_order.size();
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Topological sort testbench
// Drives adjacency rows and vertex count settings into the sorter: a short
// directed set of graphs, then random acyclic, cyclic and arbitrary graphs
// over many vertex counts. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 470;
    localparam int STALL_LIMIT = 4000;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    tss_pkg::t_in_item  item = '0;
    logic               cfg_we = 1'b0;
    logic [4:0]         cfg_wdata = '0;
    logic               res_valid;
    tss_pkg::t_out_item result;
    logic               done = 1'b0;
    int                 fail_count;
    int                 pending;

    logic [4:0]  cfg_value = 5'd16;
    logic [15:0] rows_written = '0;
    int          items = 0;
    bit          no_gaps = 1'b0;
    int          idle_cycles = 0;

    topological_sort_source_removal u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_valid     (res_valid),
        .o_result    (result)
    );

    tss_order_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_valid      (res_valid),
        .i_result     (result),
        .i_done       (done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_valid || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("topological_sort_source_removal: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned active_count(logic [4:0] v);
        return (v == 0) ? 1 : ((v > 16) ? 16 : v);
    endfunction

    task automatic send_row(int unsigned row, logic [15:0] bits, bit last);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{row_index: 4'(row), row_bits: bits, last_row: last};
        @(posedge clk);
        while (busy) @(posedge clk);
        rows_written[row] = 1'b1;
        items++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_count(logic [4:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_value = v;
    endtask

    task automatic run_graph();
        int unsigned n, kind, density, count, pick, u, v, i, tmp;
        int unsigned perm [16];
        int unsigned rank [16];
        int unsigned sel [16];
        logic [15:0] rows [16];
        logic [15:0] need;
        n = active_count(cfg_value);
        need = 16'(({32'd0, 32'd1} << n) - 1);
        kind = $urandom_range(0, 99);
        density = $urandom_range(0, 100);
        for (i = 0; i < 16; i++) begin
            perm[i] = i;
            sel[i]  = i;
        end
        for (i = n - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = perm[i]; perm[i] = perm[pick]; perm[pick] = tmp;
            pick = $urandom_range(0, i);
            tmp = sel[i]; sel[i] = sel[pick]; sel[pick] = tmp;
        end
        for (i = 0; i < n; i++) begin
            rank[perm[i]] = i;
        end
        for (u = 0; u < 16; u++) begin
            rows[u] = 16'($urandom);
            if (kind < 80 && u < n) begin
                for (v = 0; v < n; v++) begin
                    rows[u][v] = (rank[v] > rank[u]) && ($urandom_range(1, 100) <= density);
                end
            end
        end
        if (kind >= 50 && kind < 80) begin
            u = $urandom_range(0, n - 1);
            v = perm[$urandom_range(0, rank[u])];
            rows[u][v] = 1'b1;
        end
        count = n;
        if ((rows_written & need) == need && $urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, n);
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_row($urandom_range(0, 15), 16'($urandom), 1'b0);
        end
        for (i = 0; i < count; i++) begin
            send_row(sel[i], rows[sel[i]], i + 1 == count);
        end
    endtask

    initial begin
        logic [15:0] bits;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_count(5'd1);
        send_row(0, 16'h0000, 1'b1);
        send_row(0, 16'h0001, 1'b1);
        set_count(5'd0);
        send_row(0, 16'hFFFE, 1'b1);
        set_count(5'd3);
        send_row(2, 16'h0002, 1'b0);
        send_row(1, 16'h0001, 1'b0);
        send_row(0, 16'hFFF8, 1'b1);
        send_row(1, 16'h0004, 1'b0);
        send_row(2, 16'h0001, 1'b0);
        send_row(0, 16'h0002, 1'b1);
        set_count(5'd31);
        for (int i = 15; i >= 0; i--) begin
            bits = (i == 15) ? 16'h0000 : 16'(16'hFFFF << (i + 1));
            send_row(i, bits, i == 0);
        end
        send_row(15, 16'hFFFF, 1'b1);

        while (items < ITEMS) begin
            case ($urandom_range(0, 7))
                0: set_count(5'd0);
                1: set_count(5'd1);
                2: set_count(5'd16);
                3: set_count(5'd31);
                4: set_count(5'd17);
                default: set_count(5'($urandom_range(0, 31)));
            endcase
            no_gaps = ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(2, 6)) begin
                if (items < ITEMS) begin
                    run_graph();
                end
            end
        end

        wait_idle();
        repeat (64) @(posedge clk);
        done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0) begin
            $display("topological_sort_source_removal: match");
        end else begin
            $display("topological_sort_source_removal: mismatch");
        end
        $finish;
    end

endmodule

[topological_sort_source_removal.f]
src/tss_pkg.sv
src/tss_cell.sv
src/topological_sort_source_removal.sv
tb/tss_order_checker.sv
tb/tb_top.sv
